>>> rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared constants, codes and types of the MIPS subset core.
// ----------------------------------------------------------------------------
package msc_pkg;

    // Store sizes in words and the matching address widths
    localparam int unsigned PROG_WORDS = 4096;
    localparam int unsigned DATA_WORDS = 4096;
    localparam int unsigned PROG_AW    = $clog2(PROG_WORDS);
    localparam int unsigned DATA_AW    = $clog2(DATA_WORDS);

    // Payload widths
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 240;
    localparam int unsigned CFG_W      = 15;

    // Request kinds
    localparam logic [1:0] REQ_LOAD_PROG = 2'd0;
    localparam logic [1:0] REQ_LOAD_DATA = 2'd1;
    localparam logic [1:0] REQ_STEP      = 2'd2;
    localparam logic [1:0] REQ_RESTART   = 2'd3;

    // Primary opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_SLTIU = 6'h0B;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_XORI  = 6'h0E;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    // R-type codes, matched on the low 11 bits
    localparam logic [10:0] FN_SLLV    = 11'h004;
    localparam logic [10:0] FN_JR      = 11'h008;
    localparam logic [10:0] FN_SYSCALL = 11'h00C;
    localparam logic [10:0] FN_ADD     = 11'h020;
    localparam logic [10:0] FN_SUB     = 11'h022;
    localparam logic [10:0] FN_AND     = 11'h024;
    localparam logic [10:0] FN_OR      = 11'h025;
    localparam logic [10:0] FN_XOR     = 11'h026;
    localparam logic [10:0] FN_NOR     = 11'h027;
    localparam logic [10:0] FN_SLTU    = 11'h02B;
    localparam logic [10:0] FN_MUL     = 11'h098;

    // Register numbers used by the syscall report and the JAL link
    localparam logic [4:0] REG_V0 = 5'd2;
    localparam logic [4:0] REG_A0 = 5'd4;
    localparam logic [4:0] REG_A1 = 5'd5;
    localparam logic [4:0] REG_A2 = 5'd6;
    localparam logic [4:0] REG_RA = 5'd31;

    // Exit service codes
    localparam logic [31:0] SVC_EXIT   = 32'd10;
    localparam logic [31:0] SVC_EXIT2  = 32'd17;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic fetch;
        logic exec;
        logic wb;
    } msc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic step_go;
        logic out_free;
    } msc_sts_t;

    function automatic logic [31:0] swap_bytes(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

>>> rtl/msc_ctrl.sv
// ----------------------------------------------------------------------------
// msc_ctrl
// Sequencer: accept an item, fetch and execute unhalted steps, then write back.
// ----------------------------------------------------------------------------
module msc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  msc_pkg::msc_sts_t sts,
    output msc_pkg::msc_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_WB    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.step_go ? S_FETCH : S_WB;
                end
            end
            S_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_WB;
            end
            S_WB: begin
                if (sts.out_free) begin
                    cmd.wb     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/msc_dp.sv
// ----------------------------------------------------------------------------
// msc_dp
// Datapath: program and data stores, register file, ALU and result register.
// ----------------------------------------------------------------------------
module msc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  msc_pkg::msc_cmd_t                   cmd,
    output msc_pkg::msc_sts_t                   sts,
    input  logic [1:0]                          req_type,
    input  logic [11:0]                         word_index,
    input  logic [31:0]                         load_word,
    input  logic [msc_pkg::CFG_W-1:0]           program_bytes,
    input  logic [msc_pkg::CFG_W-1:0]           data_bytes,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [msc_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int unsigned PAW = msc_pkg::PROG_AW;
    localparam int unsigned DAW = msc_pkg::DATA_AW;

    // Stores
    logic [31:0] pmem [msc_pkg::PROG_WORDS];
    logic [31:0] dmem [msc_pkg::DATA_WORDS];
    logic [31:0] rf_mem [32];

    logic [31:0] pc_reg;
    logic [31:0] pmem_rdata_reg;
    logic        pfetch_ok_reg;
    logic [31:0] instr_reg;
    logic [31:0] rf_a_reg;
    logic [31:0] rf_b_reg;
    logic        rf_va_reg;
    logic        rf_vb_reg;
    logic [31:0] rf_valid_reg;
    logic [31:0] sh_v0_reg;
    logic [31:0] sh_a0_reg;
    logic [31:0] sh_a1_reg;
    logic [31:0] sh_a2_reg;
    logic [31:0] dmem_rdata_reg;
    logic        res_dok_reg;
    logic        res_wr_reg;
    logic [4:0]  res_wi_reg;
    logic [31:0] res_wv_reg;
    logic        res_lw_reg;
    logic [31:0] res_instr_reg;
    logic        res_halt_reg;
    logic        res_sys_reg;
    logic [31:0] res_sv_reg;
    logic [31:0] res_a0_reg;
    logic [31:0] res_a1_reg;
    logic [31:0] res_a2_reg;
    logic        m_tvalid_reg;
    logic [msc_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic        halt_now;
    logic        restart_now;
    logic [31:0] widx_ext;
    logic [31:0] instr_f;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [5:0]  op;
    logic [10:0] fn;
    logic [15:0] imm;
    logic [31:0] sx;
    logic [31:0] zx;
    logic [31:0] pc4;
    logic [31:0] jmp_pc;
    logic [31:0] d_addr;
    logic        d_ok;
    logic        ex_wr;
    logic [4:0]  ex_wi;
    logic [31:0] ex_wv;
    logic        ex_lw;
    logic        ex_sys;
    logic [31:0] ex_pc;
    logic [31:0] wb_value;
    logic [31:0] out_wv;
    logic [4:0]  out_wi;
    logic        out_exit;

    // Request decode at accept
    assign halt_now    = pc_reg >= 32'(program_bytes);
    assign restart_now = cmd.accept && (req_type == msc_pkg::REQ_RESTART);
    assign widx_ext    = 32'(word_index);
    assign sts.step_go  = (req_type == msc_pkg::REQ_STEP) && !halt_now;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    // Program store: load writes, fetch read issued at accept
    always_ff @(posedge aclk) begin
        if (cmd.accept && (req_type == msc_pkg::REQ_LOAD_PROG)
            && (widx_ext < 32'(msc_pkg::PROG_WORDS))) begin
            pmem[widx_ext[PAW-1:0]] <= load_word;
        end
        if (cmd.accept) begin
            pmem_rdata_reg <= pmem[pc_reg[PAW+1:2]];
            pfetch_ok_reg  <= pc_reg[31:2] < 30'(msc_pkg::PROG_WORDS);
        end
    end

    // Swap the fetched word, zero beyond the store
    assign instr_f = pfetch_ok_reg ? msc_pkg::swap_bytes(pmem_rdata_reg) : '0;

    // Register file: operand reads at fetch, write at write-back
    always_ff @(posedge aclk) begin
        if (cmd.wb && res_wr_reg) begin
            rf_mem[res_wi_reg] <= wb_value;
        end
        if (cmd.fetch) begin
            instr_reg <= instr_f;
            rf_a_reg  <= rf_mem[instr_f[25:21]];
            rf_b_reg  <= rf_mem[instr_f[20:16]];
            rf_va_reg <= rf_valid_reg[instr_f[25:21]];
            rf_vb_reg <= rf_valid_reg[instr_f[20:16]];
        end
    end

    // Valid bits and syscall shadow copies; restart clears them
    always_ff @(posedge aclk) begin
        if (!aresetn || restart_now) begin
            rf_valid_reg <= '0;
            sh_v0_reg    <= '0;
            sh_a0_reg    <= '0;
            sh_a1_reg    <= '0;
            sh_a2_reg    <= '0;
        end else if (cmd.wb && res_wr_reg) begin
            rf_valid_reg[res_wi_reg] <= 1'b1;
            if (res_wi_reg == msc_pkg::REG_V0) sh_v0_reg <= wb_value;
            if (res_wi_reg == msc_pkg::REG_A0) sh_a0_reg <= wb_value;
            if (res_wi_reg == msc_pkg::REG_A1) sh_a1_reg <= wb_value;
            if (res_wi_reg == msc_pkg::REG_A2) sh_a2_reg <= wb_value;
        end
    end

    // Operands and fields
    assign op_a   = rf_va_reg ? rf_a_reg : '0;
    assign op_b   = rf_vb_reg ? rf_b_reg : '0;
    assign op     = instr_reg[31:26];
    assign fn     = instr_reg[10:0];
    assign imm    = instr_reg[15:0];
    assign sx     = {{16{imm[15]}}, imm};
    assign zx     = {16'b0, imm};
    assign pc4    = pc_reg + 32'd4;
    assign jmp_pc = {pc4[31:28], instr_reg[25:0], 2'b00};
    assign d_addr = op_a + sx;
    assign d_ok   = (d_addr < 32'(data_bytes))
                 && (d_addr[31:2] < 30'(msc_pkg::DATA_WORDS));

    // Execute
    always_comb begin
        ex_wr  = 1'b0;
        ex_wi  = instr_reg[20:16];
        ex_wv  = '0;
        ex_lw  = 1'b0;
        ex_sys = 1'b0;
        ex_pc  = pc4;
        if (op == msc_pkg::OP_RTYPE) begin
            ex_wi = instr_reg[15:11];
            ex_wr = 1'b1;
            case (fn)
                msc_pkg::FN_ADD:  ex_wv = op_a + op_b;
                msc_pkg::FN_SUB:  ex_wv = op_a - op_b;
                msc_pkg::FN_AND:  ex_wv = op_a & op_b;
                msc_pkg::FN_OR:   ex_wv = op_a | op_b;
                msc_pkg::FN_XOR:  ex_wv = op_a ^ op_b;
                msc_pkg::FN_NOR:  ex_wv = ~(op_a | op_b);
                msc_pkg::FN_SLTU: ex_wv = {31'b0, op_a < op_b};
                msc_pkg::FN_SLLV: ex_wv = op_b << op_a[4:0];
                msc_pkg::FN_MUL:  ex_wv = op_a * op_b;
                msc_pkg::FN_JR: begin
                    ex_wr = 1'b0;
                    ex_pc = op_a;
                end
                msc_pkg::FN_SYSCALL: begin
                    ex_wr  = 1'b0;
                    ex_sys = 1'b1;
                end
                default: ex_wr = 1'b0;
            endcase
        end else begin
            case (op)
                msc_pkg::OP_ADDI: begin
                    ex_wr = 1'b1;
                    ex_wv = op_a + sx;
                end
                msc_pkg::OP_ANDI: begin
                    ex_wr = 1'b1;
                    ex_wv = op_a & zx;
                end
                msc_pkg::OP_XORI: begin
                    ex_wr = 1'b1;
                    ex_wv = op_a ^ zx;
                end
                msc_pkg::OP_SLTIU: begin
                    ex_wr = 1'b1;
                    ex_wv = {31'b0, op_a < sx};
                end
                msc_pkg::OP_LW: begin
                    ex_wr = 1'b1;
                    ex_lw = 1'b1;
                end
                msc_pkg::OP_BEQ: begin
                    if (op_a == op_b) ex_pc = pc4 + {sx[29:0], 2'b00};
                end
                msc_pkg::OP_BNE: begin
                    if (op_a != op_b) ex_pc = pc4 + {sx[29:0], 2'b00};
                end
                msc_pkg::OP_J: ex_pc = jmp_pc;
                msc_pkg::OP_JAL: begin
                    ex_wr = 1'b1;
                    ex_wi = msc_pkg::REG_RA;
                    ex_wv = pc4;
                    ex_pc = jmp_pc;
                end
                default: ex_wr = 1'b0;
            endcase
        end
    end

    // Data store: load writes at accept, store and load read at execute
    always_ff @(posedge aclk) begin
        if (cmd.accept && (req_type == msc_pkg::REQ_LOAD_DATA)
            && (widx_ext < 32'(msc_pkg::DATA_WORDS))) begin
            dmem[widx_ext[DAW-1:0]] <= load_word;
        end else if (cmd.exec && (op == msc_pkg::OP_SW) && d_ok) begin
            dmem[d_addr[DAW+1:2]] <= op_b;
        end
        if (cmd.exec) begin
            dmem_rdata_reg <= dmem[d_addr[DAW+1:2]];
            res_dok_reg    <= d_ok;
        end
    end

    // Program counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else if (cmd.accept) begin
            if (restart_now || ((req_type == msc_pkg::REQ_STEP) && halt_now)) begin
                pc_reg <= '0;
            end
        end else if (cmd.exec) begin
            pc_reg <= ex_pc;
        end
    end

    // Result fields: cleared at accept (halt flag set there), filled at execute
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            res_wr_reg    <= 1'b0;
            res_wi_reg    <= '0;
            res_wv_reg    <= '0;
            res_lw_reg    <= 1'b0;
            res_instr_reg <= '0;
            res_halt_reg  <= (req_type == msc_pkg::REQ_STEP) && halt_now;
            res_sys_reg   <= 1'b0;
            res_sv_reg    <= '0;
            res_a0_reg    <= '0;
            res_a1_reg    <= '0;
            res_a2_reg    <= '0;
        end else if (cmd.exec) begin
            res_wr_reg    <= ex_wr && (ex_wi != 5'd0);
            res_wi_reg    <= ex_wi;
            res_wv_reg    <= ex_wv;
            res_lw_reg    <= ex_lw;
            res_instr_reg <= instr_reg;
            res_sys_reg   <= ex_sys;
            res_sv_reg    <= ex_sys ? sh_v0_reg : '0;
            res_a0_reg    <= ex_sys ? sh_a0_reg : '0;
            res_a1_reg    <= ex_sys ? sh_a1_reg : '0;
            res_a2_reg    <= ex_sys ? sh_a2_reg : '0;
        end
    end

    // Write-back value and reported fields
    assign wb_value = res_lw_reg ? (res_dok_reg ? dmem_rdata_reg : '0) : res_wv_reg;
    assign out_wv   = res_wr_reg ? wb_value : '0;
    assign out_wi   = res_wr_reg ? res_wi_reg : '0;
    assign out_exit = res_sys_reg
                   && ((res_sv_reg == msc_pkg::SVC_EXIT) || (res_sv_reg == msc_pkg::SVC_EXIT2));

    // Output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.wb) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wb) begin
            m_tdata_reg <= {7'b0, out_exit, res_a2_reg, res_a1_reg, res_a0_reg, res_sv_reg,
                            res_sys_reg, res_halt_reg, out_wv, out_wi, res_wr_reg,
                            res_instr_reg, pc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/mips_subset_core.sv
// ----------------------------------------------------------------------------
// mips_subset_core
// MIPS integer subset core stepped by stream items, with an APB register port.
// ----------------------------------------------------------------------------
// Flow: loads, restarts and halted steps go from accept straight to write-back;
//   an executed step passes through fetch, execute and write-back.
// Items: one at a time; the next is accepted only after write-back, which an
//   output stall holds; steps wait on synchronous program, register, data reads.
// Reset: aresetn synchronous active low; clears pc, register valid bits and
//   configuration. Program and data stores are not cleared.
module mips_subset_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [11:0] word_index, [43:12] load_word, rest zero
    input  logic [msc_pkg::IN_DATA_W-1:0]      s_tdata,
    // [1:0] req_type
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] next_pc, [63:32] instr_word, [64] reg_written, [69:65] reg_index,
    // [101:70] reg_value, [102] halted, [103] syscall_seen,
    // [135:104] service_code, [167:136] arg_a0, [199:168] arg_a1,
    // [231:200] arg_a2, [232] exit_request, rest zero
    output logic [msc_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [msc_pkg::CFG_W-1:0] prog_bytes_reg;
    logic [msc_pkg::CFG_W-1:0] data_bytes_reg;
    msc_pkg::msc_cmd_t         cmd;
    msc_pkg::msc_sts_t         sts;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prog_bytes_reg <= '0;
            data_bytes_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                data_bytes_reg <= pwdata[msc_pkg::CFG_W-1:0];
            end else begin
                prog_bytes_reg <= pwdata[msc_pkg::CFG_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(data_bytes_reg) : 32'(prog_bytes_reg);

    msc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    msc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (s_tuser),
        .word_index    (s_tdata[11:0]),
        .load_word     (s_tdata[43:12]),
        .program_bytes (prog_bytes_reg),
        .data_bytes    (data_bytes_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

>>> rtl/msc_checker.sv
// ----------------------------------------------------------------------------
// msc_checker
// Port-level checks of the MIPS subset core, bound to the top level.
// ----------------------------------------------------------------------------
module msc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [msc_pkg::OUT_DATA_W-1:0] m_tdata
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: no accept right after an accept
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // A halt reports pc zero and no instruction
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[102] |-> (m_tdata[31:0] == 32'd0) && (m_tdata[63:32] == 32'd0))
        else $error("halt with nonzero pc or instruction");

    // A reported write never targets r0; no write reports zeros
    a_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[64] ? (m_tdata[69:65] != 5'd0)
                                  : ((m_tdata[69:65] == 5'd0) && (m_tdata[101:70] == 32'd0))))
        else $error("bad register write report");

    // Reset empties the output
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind mips_subset_core msc_checker u_msc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/mips_subset_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_core_tb
// Self-checking bench for the MIPS subset core: a directed table of loads,
// steps, restarts and halts, a short table at the largest lengths, then random
// programs under several length settings that stay inside the filled words.
// Every result item is checked field by field against an in-bench model of
// the core, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module mips_subset_core_tb;

    localparam int unsigned CYCLE_LIMIT    = 1000000;
    localparam logic [2:0]  ADDR_PROG_LEN  = 3'd0;
    localparam logic [2:0]  ADDR_DATA_LEN  = 3'd4;
    localparam logic [5:0]  OP_UNDEFINED   = 6'h3F;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned PROG_FILL      = 128;
    localparam int unsigned DATA_FILL      = 128;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [31:0] instr_word;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        halted;
        logic        syscall_seen;
        logic [31:0] service_code;
        logic [31:0] arg_a0;
        logic [31:0] arg_a1;
        logic [31:0] arg_a2;
        logic        exit_request;
    } core_result_t;

    typedef struct {
        logic [1:0]  req;
        logic [11:0] idx;
        logic [31:0] word;
        logic        typed;
        logic [31:0] want_pc;
        logic        want_halt;
    } stim_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [msc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]                     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [msc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [2:0]                     paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    // Model state
    logic [31:0] gpr [32];
    logic [31:0] core_pc;
    logic [31:0] prog_mem [msc_pkg::PROG_WORDS];
    logic [31:0] data_mem [msc_pkg::DATA_WORDS];
    logic [14:0] prog_len;
    logic [14:0] data_len;

    core_result_t expected_results[$];
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;
    bit           calm = 1'b0;

    mips_subset_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // Abort on runaway
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [4:0] rd, input logic [10:0] fn);
        return {msc_pkg::OP_RTYPE, rs, rt, rd, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] byte_rev(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // Model one accepted item and return the result it causes
    task automatic run_core_item(input logic [1:0] req, input logic [11:0] idx,
                                 input logic [31:0] word, output core_result_t r);
        logic [31:0] ins, a, b, sx, wv, ad;
        logic [5:0]  op;
        logic [4:0]  wi;
        logic        wr;
        r  = '0;
        wr = 1'b0;
        wv = '0;
        wi = '0;
        case (req)
            msc_pkg::REQ_LOAD_PROG: prog_mem[idx] = word;
            msc_pkg::REQ_LOAD_DATA: data_mem[idx] = word;
            msc_pkg::REQ_RESTART: begin
                foreach (gpr[i]) gpr[i] = '0;
                core_pc = '0;
            end
            default: begin
                if (core_pc >= {17'd0, prog_len}) begin
                    core_pc  = '0;
                    r.halted = 1'b1;
                end else begin
                    ins = (core_pc[31:2] < msc_pkg::PROG_WORDS) ?
                          byte_rev(prog_mem[core_pc[13:2]]) : '0;
                    op  = ins[31:26];
                    a   = gpr[ins[25:21]];
                    b   = gpr[ins[20:16]];
                    sx  = {{16{ins[15]}}, ins[15:0]};
                    ad  = a + sx;
                    core_pc = core_pc + 32'd4;
                    r.instr_word = ins;
                    if (op == msc_pkg::OP_RTYPE) begin
                        wi = ins[15:11];
                        wr = 1'b1;
                        case (ins[10:0])
                            msc_pkg::FN_ADD:  wv = a + b;
                            msc_pkg::FN_SUB:  wv = a - b;
                            msc_pkg::FN_AND:  wv = a & b;
                            msc_pkg::FN_OR:   wv = a | b;
                            msc_pkg::FN_XOR:  wv = a ^ b;
                            msc_pkg::FN_NOR:  wv = ~(a | b);
                            msc_pkg::FN_SLTU: wv = {31'd0, a < b};
                            msc_pkg::FN_SLLV: wv = b << a[4:0];
                            msc_pkg::FN_MUL:  wv = a * b;
                            msc_pkg::FN_JR: begin
                                wr = 1'b0;
                                core_pc = a;
                            end
                            msc_pkg::FN_SYSCALL: begin
                                wr = 1'b0;
                                r.syscall_seen = 1'b1;
                                r.service_code = gpr[msc_pkg::REG_V0];
                                r.arg_a0 = gpr[msc_pkg::REG_A0];
                                r.arg_a1 = gpr[msc_pkg::REG_A1];
                                r.arg_a2 = gpr[msc_pkg::REG_A2];
                                r.exit_request = (gpr[msc_pkg::REG_V0] == msc_pkg::SVC_EXIT) ||
                                                 (gpr[msc_pkg::REG_V0] == msc_pkg::SVC_EXIT2);
                            end
                            default: wr = 1'b0;
                        endcase
                    end else begin
                        wi = ins[20:16];
                        case (op)
                            msc_pkg::OP_ADDI:  begin wr = 1'b1; wv = ad; end
                            msc_pkg::OP_ANDI:  begin wr = 1'b1; wv = a & {16'd0, ins[15:0]}; end
                            msc_pkg::OP_XORI:  begin wr = 1'b1; wv = a ^ {16'd0, ins[15:0]}; end
                            msc_pkg::OP_SLTIU: begin wr = 1'b1; wv = {31'd0, a < sx}; end
                            msc_pkg::OP_LW: begin
                                wr = 1'b1;
                                wv = (ad < {17'd0, data_len} &&
                                      ad[31:2] < msc_pkg::DATA_WORDS) ?
                                     data_mem[ad[13:2]] : '0;
                            end
                            msc_pkg::OP_SW: begin
                                if (ad < {17'd0, data_len} && ad[31:2] < msc_pkg::DATA_WORDS)
                                    data_mem[ad[13:2]] = b;
                            end
                            msc_pkg::OP_BEQ: if (a == b) core_pc = core_pc + (sx << 2);
                            msc_pkg::OP_BNE: if (a != b) core_pc = core_pc + (sx << 2);
                            msc_pkg::OP_J: core_pc = {core_pc[31:28], ins[25:0], 2'b00};
                            msc_pkg::OP_JAL: begin
                                wr = 1'b1;
                                wi = msc_pkg::REG_RA;
                                wv = core_pc;
                                core_pc = {core_pc[31:28], ins[25:0], 2'b00};
                            end
                            default: ;
                        endcase
                    end
                    // r0 writes are discarded
                    if (wr && wi != 5'd0) begin
                        gpr[wi] = wv;
                        r.reg_written = 1'b1;
                        r.reg_index = wi;
                        r.reg_value = wv;
                    end
                end
            end
        endcase
        r.next_pc = core_pc;
    endtask

    // Ready side: random back-pressure, none while calm
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 27);
    end

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Check each result item against the oldest expectation
    always @(posedge aclk) begin
        core_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{next_pc: m_tdata[31:0], instr_word: m_tdata[63:32],
                    reg_written: m_tdata[64], reg_index: m_tdata[69:65],
                    reg_value: m_tdata[101:70], halted: m_tdata[102],
                    syscall_seen: m_tdata[103], service_code: m_tdata[135:104],
                    arg_a0: m_tdata[167:136], arg_a1: m_tdata[199:168],
                    arg_a2: m_tdata[231:200], exit_request: m_tdata[232]};
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result item: actual %h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                cmp_field("next_pc", want.next_pc, got.next_pc);
                cmp_field("instr_word", want.instr_word, got.instr_word);
                cmp_field("reg_written", want.reg_written, got.reg_written);
                cmp_field("reg_index", want.reg_index, got.reg_index);
                cmp_field("reg_value", want.reg_value, got.reg_value);
                cmp_field("halted", want.halted, got.halted);
                cmp_field("syscall_seen", want.syscall_seen, got.syscall_seen);
                cmp_field("service_code", want.service_code, got.service_code);
                cmp_field("arg_a0", want.arg_a0, got.arg_a0);
                cmp_field("arg_a1", want.arg_a1, got.arg_a1);
                cmp_field("arg_a2", want.arg_a2, got.arg_a2);
                cmp_field("exit_request", want.exit_request, got.exit_request);
            end
        end
    end

    // Offer one item, hold it until accepted, then queue its expected result
    task automatic send_item(input logic [1:0] req, input logic [11:0] idx,
                             input logic [31:0] word, output core_result_t r);
        int gap;
        if (!calm && $urandom_range(0, 99) < 27) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'd0, word, idx};
        do @(posedge aclk); while (!s_tready);
        run_core_item(req, idx, word, r);
        expected_results.push_back(r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write: setup then access, taken at the access edge
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (addr == ADDR_PROG_LEN) prog_len = value[14:0];
        else                       data_len = value[14:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_lengths(input logic [31:0] p, input logic [31:0] d);
        wait_drained();
        write_reg(ADDR_PROG_LEN, p);
        write_reg(ADDR_DATA_LEN, d);
    endtask

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
    endfunction

    // Random instruction with mostly useful operands
    function automatic logic [31:0] rand_instr();
        logic [4:0]  rs, rt, rd;
        logic [15:0] imm, near;
        rs   = pick_reg();
        rt   = pick_reg();
        rd   = pick_reg();
        imm  = 16'($urandom);
        near = 16'($urandom_range(0, 12)) - 16'd6;
        case ($urandom_range(0, 21))
            0:  return enc_r(rs, rt, rd, msc_pkg::FN_ADD);
            1:  return enc_r(rs, rt, rd, msc_pkg::FN_SUB);
            2:  return enc_r(rs, rt, rd, msc_pkg::FN_AND);
            3:  return enc_r(rs, rt, rd, msc_pkg::FN_OR);
            4:  return enc_r(rs, rt, rd, msc_pkg::FN_XOR);
            5:  return enc_r(rs, rt, rd, msc_pkg::FN_NOR);
            6:  return enc_r(rs, rt, rd, msc_pkg::FN_SLTU);
            7:  return enc_r(rs, rt, rd, msc_pkg::FN_SLLV);
            8:  return enc_r(rs, rt, rd, msc_pkg::FN_MUL);
            9:  return enc_r(rs, 5'd0, 5'd0, msc_pkg::FN_JR);
            10: return enc_r(5'd0, 5'd0, 5'd0, msc_pkg::FN_SYSCALL);
            11: return enc_i(msc_pkg::OP_ADDI, rs, rt, imm);
            12: return enc_i(msc_pkg::OP_ANDI, rs, rt, imm);
            13: return enc_i(msc_pkg::OP_XORI, rs, rt, imm);
            14: return enc_i(msc_pkg::OP_SLTIU, rs, rt, imm);
            15: return enc_i(msc_pkg::OP_LW, ($urandom_range(0, 1) ? 5'd0 : rs), rt,
                             16'($urandom_range(0, 300)) - 16'd20);
            16: return enc_i(msc_pkg::OP_SW, ($urandom_range(0, 1) ? 5'd0 : rs), rt,
                             16'($urandom_range(0, 300)) - 16'd20);
            17: return enc_i(msc_pkg::OP_BEQ, rs, rt, near);
            18: return enc_i(msc_pkg::OP_BNE, rs, rt, near);
            19: return {($urandom_range(0, 1) ? msc_pkg::OP_J : msc_pkg::OP_JAL),
                        26'($urandom_range(0, 80))};
            20: return enc_i(msc_pkg::OP_ADDI, 5'd0, msc_pkg::REG_V0,
                             ($urandom_range(0, 1) ? 16'd10 : 16'd17));
            default: return ($urandom_range(0, 1) ? 32'($urandom) :
                             enc_i(OP_UNDEFINED, rs, rt, imm));
        endcase
    endfunction

    // One random phase under the current lengths
    task automatic random_phase(input int count, input bit pause_midway);
        core_result_t r;
        int           roll;
        int           words;
        words = (prog_len + 3) / 4;
        for (int n = 0; n < count; n++) begin
            calm = (n >= count / 3) && (n < count / 3 + 40);
            if (pause_midway && n == count / 2) wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 68)
                send_item(msc_pkg::REQ_STEP, 12'($urandom), 32'($urandom), r);
            else if (roll < 88)
                send_item(msc_pkg::REQ_LOAD_PROG,
                          (words > 0 && roll < 85) ? 12'($urandom_range(0, words - 1)) :
                                                     12'($urandom),
                          byte_rev(rand_instr()), r);
            else if (roll < 97)
                send_item(msc_pkg::REQ_LOAD_DATA, 12'($urandom_range(0, 80)),
                          32'($urandom), r);
            else
                send_item(msc_pkg::REQ_RESTART, 12'($urandom), 32'($urandom), r);
        end
        calm = 1'b0;
    endtask

    stim_row_t    plan [$];
    core_result_t res;

    // Walk the stimulus table, checking the typed rows on the spot
    task automatic walk_plan();
        foreach (plan[i]) begin
            send_item(plan[i].req, plan[i].idx, plan[i].word, res);
            if (plan[i].typed && (res.next_pc !== plan[i].want_pc ||
                                  res.halted !== plan[i].want_halt)) begin
                $display("%0t directed row %0d: expected pc %h halt %b actual pc %h halt %b",
                         $time, i, plan[i].want_pc, plan[i].want_halt,
                         res.next_pc, res.halted);
                error_count++;
            end
        end
    endtask

    initial begin
        foreach (gpr[i]) gpr[i] = '0;
        core_pc  = '0;
        prog_len = '0;
        data_len = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero lengths: every step halts
        send_item(msc_pkg::REQ_STEP, 12'hFFF, 32'hFFFF_FFFF, res);
        send_item(msc_pkg::REQ_RESTART, 12'h000, 32'h0, res);

        // Fill the low words of both stores; lengths stay inside them
        for (int i = 0; i < PROG_FILL; i++)
            send_item(msc_pkg::REQ_LOAD_PROG, 12'(i), byte_rev(rand_instr()), res);
        for (int i = 0; i < DATA_FILL; i++)
            send_item(msc_pkg::REQ_LOAD_DATA, 12'(i), 32'($urandom), res);

        set_lengths(32'd64, 32'd64);

        // Directed table
        plan = '{
            '{msc_pkg::REQ_RESTART, 12'd0, 32'h0, 1'b1, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd0,
              byte_rev(enc_i(msc_pkg::OP_ADDI, 5'd0, msc_pkg::REG_V0, 16'd10)),
              1'b1, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd1,
              byte_rev(enc_r(5'd0, 5'd0, 5'd0, msc_pkg::FN_SYSCALL)),
              1'b1, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd2,
              byte_rev(enc_i(msc_pkg::OP_ADDI, 5'd0, msc_pkg::REG_A0, 16'hFFFF)),
              1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd3,
              byte_rev(enc_r(msc_pkg::REG_A0, msc_pkg::REG_A0, msc_pkg::REG_A1,
                             msc_pkg::FN_MUL)),
              1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd4,
              byte_rev(enc_i(msc_pkg::OP_SW, 5'd0, msc_pkg::REG_A0, 16'd60)),
              1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd5,
              byte_rev(enc_i(msc_pkg::OP_LW, 5'd0, msc_pkg::REG_A2, 16'd62)),
              1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd6,
              byte_rev(enc_i(msc_pkg::OP_ADDI, msc_pkg::REG_A0, 5'd0, 16'd1)),
              1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd7,
              byte_rev(enc_i(msc_pkg::OP_SLTIU, 5'd0, 5'd3, 16'hFFFF)),
              1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd8,
              byte_rev(enc_i(OP_UNDEFINED, 5'd1, 5'd1, 16'h1234)),
              1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd9, byte_rev({msc_pkg::OP_JAL, 26'd16}),
              1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_DATA, 12'd4095, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd4095, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b1, 32'd4, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b1, 32'd8, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b0, 32'd0, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b1, 32'd64, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b1, 32'd0, 1'b1}
        };
        walk_plan();

        // Largest lengths: jump past the program store, where fetch and data read zero
        set_lengths(32'h7FFF, 32'h7FFF);
        plan = '{
            '{msc_pkg::REQ_RESTART, 12'd0, 32'h0, 1'b1, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd0,
              byte_rev(enc_i(msc_pkg::OP_ADDI, 5'd0, 5'd8, 16'h4000)),
              1'b1, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd1,
              byte_rev(enc_i(msc_pkg::OP_LW, 5'd8, 5'd9, 16'd0)),
              1'b1, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd2,
              byte_rev(enc_i(msc_pkg::OP_SW, 5'd8, 5'd8, 16'd0)),
              1'b1, 32'd0, 1'b0},
            '{msc_pkg::REQ_LOAD_PROG, 12'd3,
              byte_rev(enc_r(5'd8, 5'd0, 5'd0, msc_pkg::FN_JR)),
              1'b1, 32'd0, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b1, 32'd4, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b1, 32'd8, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b1, 32'd12, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b1, 32'd16384, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b1, 32'd16388, 1'b0},
            '{msc_pkg::REQ_STEP, 12'd0, 32'h0, 1'b1, 32'd16392, 1'b0}
        };
        walk_plan();

        // Random phases across length settings within the filled words
        set_lengths(32'd64, 32'd64);
        random_phase(260, 1'b1);
        set_lengths(32'd512, 32'd512);
        random_phase(200, 1'b0);
        set_lengths(32'd4, 32'd0);
        random_phase(150, 1'b0);
        set_lengths(32'd256, 32'd128);
        random_phase(390, 1'b0);

        wait_drained();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/msc_pkg.sv
rtl/msc_ctrl.sv
rtl/msc_dp.sv
rtl/mips_subset_core.sv
rtl/msc_checker.sv
tb/mips_subset_core_tb.sv
